// File: src/lcas_pkg.sv
// ----------------------------------------------------------------------------
// lcas_pkg
// Shared types and constants of the logic channel activity statistics block.
// ----------------------------------------------------------------------------
package lcas_pkg;

	localparam int CHANNELS_DEF    = 8;
	localparam int COUNT_WIDTH_DEF = 32;

	localparam int FUNC_W     = 2;
	localparam int SAMPLE_W   = 8;
	localparam int CHAN_IDX_W = 3;
	localparam int MASK_W     = 8;
	localparam int OUT_CNT_W  = 32;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_PUSH  = 2'd0,
		FUNC_READ  = 2'd1,
		FUNC_CLEAR = 2'd2
	} func_t;

	typedef struct packed {
		logic [FUNC_W-1:0]     func;
		logic [SAMPLE_W-1:0]   sample_value;
		logic [CHAN_IDX_W-1:0] channel;
	} in_item_t;

	typedef struct packed {
		logic [MASK_W-1:0]    active_mask;
		logic [OUT_CNT_W-1:0] high_count;
		logic [OUT_CNT_W-1:0] low_count;
		logic [OUT_CNT_W-1:0] edge_count;
	} out_item_t;

	// Broadcast from the top level to every cell
	typedef struct packed {
		logic push;
		logic clear;
		logic have_prev;
	} cell_ctrl_t;

endpackage

// File: src/lcas_stream_if.sv
// ----------------------------------------------------------------------------
// lcas_stream_if
// Valid/ready channel carrying one item per handshake.
// ----------------------------------------------------------------------------
interface lcas_stream_if #(
	parameter type item_t = logic
) ();
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: src/lcas_cell.sv
// ----------------------------------------------------------------------------
// lcas_cell
// Per-channel statistics cell: previous level, toggle flag and three
// saturating counters; passes the selected counters down the read chain.
// ----------------------------------------------------------------------------
module lcas_cell #(
	parameter int COUNT_WIDTH = lcas_pkg::COUNT_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lcas_pkg::cell_ctrl_t   ctrl,
	input  logic                   sample_bit,
	input  logic                   sel,
	input  logic [COUNT_WIDTH-1:0] high_in,
	input  logic [COUNT_WIDTH-1:0] low_in,
	input  logic [COUNT_WIDTH-1:0] edge_in,
	output logic [COUNT_WIDTH-1:0] high_out,
	output logic [COUNT_WIDTH-1:0] low_out,
	output logic [COUNT_WIDTH-1:0] edge_out,
	output logic                   toggled
);

	logic                   prev_q;
	logic                   tog_q;
	logic [COUNT_WIDTH-1:0] high_q;
	logic [COUNT_WIDTH-1:0] low_q;
	logic [COUNT_WIDTH-1:0] edge_q;
	logic                   classify;
	logic                   diff;

	assign classify = ctrl.push && ctrl.have_prev;
	assign diff     = prev_q ^ sample_bit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= 1'b0;
			tog_q  <= 1'b0;
			high_q <= '0;
			low_q  <= '0;
			edge_q <= '0;
		end else if (ctrl.clear) begin
			prev_q <= 1'b0;
			tog_q  <= 1'b0;
			high_q <= '0;
			low_q  <= '0;
			edge_q <= '0;
		end else if (ctrl.push) begin
			prev_q <= sample_bit;
			if (classify) begin
				if (diff) begin
					tog_q <= 1'b1;
					if (edge_q != '1) edge_q <= edge_q + COUNT_WIDTH'(1);
				end else if (prev_q) begin
					if (high_q != '1) high_q <= high_q + COUNT_WIDTH'(1);
				end else begin
					if (low_q != '1) low_q <= low_q + COUNT_WIDTH'(1);
				end
			end
		end
	end

	// read chain: take own counters when selected, else forward neighbor's
	assign high_out = sel ? high_q : high_in;
	assign low_out  = sel ? low_q  : low_in;
	assign edge_out = sel ? edge_q : edge_in;
	assign toggled  = tog_q;

endmodule

// File: src/logic_channel_activity_stats_core.sv
// ----------------------------------------------------------------------------
// logic_channel_activity_stats_core
// Logic-analyzer channel statistics: a row of per-channel cells counting
// steady-high, steady-low and transition samples, plus a toggle mask.
//
//   channel    | dir | payload                                   | handshake
//   sample_in  | in  | func, sample_value, channel               | valid/ready
//   stats_out  | out | active_mask, high_count, low_count,       | valid/ready
//              |     | edge_count                                |
//
// One item per cycle while the output is not stalled. Cells update at the
// accepting edge and the read stage registers the channel; as it advances,
// the selected counters pass down the cell chain into the output register.
// arst_n clears all statistics and the pipeline; no clearing pass is needed.
// A stalled output holds its result; input drops ready only while both the
// read stage and the output register hold items and the output is stalled.
// ----------------------------------------------------------------------------
module logic_channel_activity_stats_core #(
	parameter int CHANNELS    = lcas_pkg::CHANNELS_DEF,
	parameter int COUNT_WIDTH = lcas_pkg::COUNT_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	lcas_stream_if.sink   sample_in,
	lcas_stream_if.source stats_out
);

	logic                            accept;
	logic                            adv_s1;
	logic                            valid_s1;
	logic [lcas_pkg::CHAN_IDX_W-1:0] channel_s1;
	logic                            have_prev_q;
	logic                            out_valid_q;
	lcas_pkg::out_item_t             out_q;
	lcas_pkg::cell_ctrl_t            ctrl;
	logic [CHANNELS-1:0]             sel;
	logic [CHANNELS-1:0]             tog;
	logic [CHANNELS-1:0]             sample_bits;
	logic [lcas_pkg::MASK_W-1:0]     mask;
	logic [COUNT_WIDTH-1:0]          high_chain [CHANNELS+1];
	logic [COUNT_WIDTH-1:0]          low_chain  [CHANNELS+1];
	logic [COUNT_WIDTH-1:0]          edge_chain [CHANNELS+1];

	assign adv_s1          = valid_s1 && (!out_valid_q || stats_out.ready);
	assign sample_in.ready = !valid_s1 || adv_s1;
	assign accept          = sample_in.valid && sample_in.ready;

	always_comb begin
		ctrl.push      = 1'b0;
		ctrl.clear     = 1'b0;
		ctrl.have_prev = have_prev_q;
		unique case (sample_in.data.func)
			lcas_pkg::FUNC_PUSH:  ctrl.push  = accept;
			lcas_pkg::FUNC_CLEAR: ctrl.clear = accept;
			default:              ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
		end else if (ctrl.clear) begin
			have_prev_q <= 1'b0;
		end else if (ctrl.push) begin
			have_prev_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) channel_s1 <= sample_in.data.channel;
	end

	assign high_chain[0] = '0;
	assign low_chain[0]  = '0;
	assign edge_chain[0] = '0;

	for (genvar i = 0; i < CHANNELS; i++) begin : g_cell
		// channels beyond the sample width get no input bit and read as low
		if (i < lcas_pkg::SAMPLE_W) begin : g_bit
			assign sample_bits[i] = sample_in.data.sample_value[i];
			assign sel[i] = (channel_s1 == lcas_pkg::CHAN_IDX_W'(i));
		end else begin : g_nobit
			assign sample_bits[i] = 1'b0;
			assign sel[i] = 1'b0;
		end

		lcas_cell #(
			.COUNT_WIDTH(COUNT_WIDTH)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.sample_bit(sample_bits[i]),
			.sel       (sel[i]),
			.high_in   (high_chain[i]),
			.low_in    (low_chain[i]),
			.edge_in   (edge_chain[i]),
			.high_out  (high_chain[i+1]),
			.low_out   (low_chain[i+1]),
			.edge_out  (edge_chain[i+1]),
			.toggled   (tog[i])
		);
	end

	for (genvar j = 0; j < lcas_pkg::MASK_W; j++) begin : g_mask
		if (j < CHANNELS) begin : g_on
			assign mask[j] = tog[j];
		end else begin : g_off
			assign mask[j] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (stats_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_q.active_mask <= mask;
			out_q.high_count  <= lcas_pkg::OUT_CNT_W'(high_chain[CHANNELS]);
			out_q.low_count   <= lcas_pkg::OUT_CNT_W'(low_chain[CHANNELS]);
			out_q.edge_count  <= lcas_pkg::OUT_CNT_W'(edge_chain[CHANNELS]);
		end
	end

	assign stats_out.valid = out_valid_q;
	assign stats_out.data  = out_q;

endmodule

// File: src/lcas_checker.sv
// ----------------------------------------------------------------------------
// lcas_checker
// Port-level checks of the channel statistics block, bound to the top level.
// ----------------------------------------------------------------------------
module lcas_checker #(
	parameter int CHANNELS = lcas_pkg::CHANNELS_DEF
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_ready,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic [lcas_pkg::MASK_W-1:0]        active_mask,
	input logic [lcas_pkg::OUT_CNT_W-1:0]     edge_count
);

	// a result waiting on the sink is not withdrawn
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// input only backs off when the output register is full
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty output");

	// no activity reported for channels that do not exist
	a_mask_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((active_mask >> CHANNELS) == '0))
		else $error("activity on a channel beyond CHANNELS");

	// any transition counted implies some channel marked active
	a_edge_mask: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (edge_count != '0) |-> (active_mask != '0))
		else $error("transitions without activity mask");

endmodule

bind logic_channel_activity_stats_core lcas_checker #(
	.CHANNELS(CHANNELS)
) u_lcas_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (sample_in.ready),
	.out_valid  (stats_out.valid),
	.out_ready  (stats_out.ready),
	.active_mask(stats_out.data.active_mask),
	.edge_count (stats_out.data.edge_count)
);

// File: tb/logic_channel_activity_stats_core_tb.sv
// ----------------------------------------------------------------------------
// logic_channel_activity_stats_core_tb
// Self-checking bench for the channel statistics core. A queue-fed driver
// offers items in bursts and a monitor compares each result against a
// predictor that tracks the previous sample, toggle mask and saturating
// per-channel counters. Directed corner items come first, then random ones
// under random sender gaps, receiver stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module logic_channel_activity_stats_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [lcas_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam int NCH         = lcas_pkg::CHANNELS_DEF;
	localparam int IDLE_LIMIT  = 1000;
	localparam int HOLD_CYCLES = 80;
	localparam int HOLD_AT     = 200;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                lcas_in_valid_unused_guard;
	logic                in_valid = 1'b0;
	lcas_pkg::in_item_t  in_data  = '0;
	logic                out_ready = 1'b0;
	logic                in_taken  = 1'b0;

	lcas_stream_if #(.item_t(lcas_pkg::in_item_t))  sample_if ();
	lcas_stream_if #(.item_t(lcas_pkg::out_item_t)) stats_if ();

	assign sample_if.valid = in_valid;
	assign sample_if.data  = in_data;
	assign stats_if.ready  = out_ready;
	assign lcas_in_valid_unused_guard = in_valid;

	logic_channel_activity_stats_core #(
		.CHANNELS    (lcas_pkg::CHANNELS_DEF),
		.COUNT_WIDTH (lcas_pkg::COUNT_WIDTH_DEF)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_in (sample_if),
		.stats_out (stats_if)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// predictor state
	logic [lcas_pkg::SAMPLE_W-1:0]  prev_sample;
	logic                           have_prev;
	logic [lcas_pkg::MASK_W-1:0]    toggled;
	logic [lcas_pkg::OUT_CNT_W-1:0] high_cnt [NCH];
	logic [lcas_pkg::OUT_CNT_W-1:0] low_cnt  [NCH];
	logic [lcas_pkg::OUT_CNT_W-1:0] edge_cnt [NCH];

	lcas_pkg::in_item_t  pending_items [$];
	lcas_pkg::out_item_t expected_stats [$];
	int                  accepted_items = 0;
	int                  mismatches = 0;
	int                  idle_cycles = 0;

	function automatic void stats_clear();
		prev_sample = '0;
		have_prev   = 1'b0;
		toggled     = '0;
		for (int i = 0; i < NCH; i++) begin
			high_cnt[i] = '0;
			low_cnt[i]  = '0;
			edge_cnt[i] = '0;
		end
	endfunction

	function automatic lcas_pkg::out_item_t stats_apply(lcas_pkg::in_item_t it);
		lcas_pkg::out_item_t r;
		logic [lcas_pkg::SAMPLE_W-1:0] diff;
		if (it.func == lcas_pkg::FUNC_PUSH) begin
			if (have_prev) begin
				diff = prev_sample ^ it.sample_value;
				toggled |= diff;
				for (int i = 0; i < NCH; i++) begin
					if (diff[i]) begin
						if (edge_cnt[i] != '1) edge_cnt[i]++;
					end else if (prev_sample[i]) begin
						if (high_cnt[i] != '1) high_cnt[i]++;
					end else begin
						if (low_cnt[i] != '1) low_cnt[i]++;
					end
				end
			end
			prev_sample = it.sample_value;
			have_prev   = 1'b1;
		end else if (it.func == lcas_pkg::FUNC_CLEAR) begin
			stats_clear();
		end
		// read and the unused code leave the state alone
		r.active_mask = toggled;
		r.high_count  = high_cnt[it.channel];
		r.low_count   = low_cnt[it.channel];
		r.edge_count  = edge_cnt[it.channel];
		return r;
	endfunction

	task automatic add_item(logic [lcas_pkg::FUNC_W-1:0] f,
			logic [lcas_pkg::SAMPLE_W-1:0] s,
			logic [lcas_pkg::CHAN_IDX_W-1:0] c);
		lcas_pkg::in_item_t it;
		it.func         = f;
		it.sample_value = s;
		it.channel      = c;
		pending_items.push_back(it);
	endtask

	// input acceptance: predict and record
	always @(posedge clk) begin
		if (arst_n) begin
			in_taken <= in_valid && sample_if.ready;
			if (in_valid && sample_if.ready) begin
				expected_stats.push_back(stats_apply(in_data));
				accepted_items++;
			end
		end
	end

	// driver: bursts with random gaps
	int burst_left = 4;
	int gap_left   = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_taken) begin
				// item still waiting for ready
			end else if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left--;
			end else if (pending_items.size() > 0) begin
				in_data  <= pending_items.pop_front();
				in_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 24);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: stall pattern by mode, plus one long hold-off
	int rx_mode = 0;
	int rx_mode_left = 40;
	int rx_cycle = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	always @(negedge clk) begin
		if (arst_n) begin
			rx_cycle++;
			if (rx_mode_left == 0) begin
				rx_mode      = $urandom_range(0, 3);
				rx_mode_left = $urandom_range(20, 80);
			end else begin
				rx_mode_left--;
			end
			if (!hold_done && accepted_items >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (rx_mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= (rx_cycle % 4 == 0);
					default: out_ready <= ($urandom_range(0, 4) != 0);
				endcase
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		lcas_pkg::out_item_t got;
		lcas_pkg::out_item_t want;
		if (arst_n && stats_if.valid && out_ready) begin
			got = stats_if.data;
			if (expected_stats.size() == 0) begin
				$error("unexpected result: mask %0h high %0h low %0h edge %0h",
					got.active_mask, got.high_count, got.low_count, got.edge_count);
				mismatches++;
			end else begin
				want = expected_stats.pop_front();
				if (got.active_mask !== want.active_mask) begin
					$error("active_mask: expected %0h, got %0h",
						want.active_mask, got.active_mask);
					mismatches++;
				end
				if (got.high_count !== want.high_count) begin
					$error("high_count: expected %0d, got %0d",
						want.high_count, got.high_count);
					mismatches++;
				end
				if (got.low_count !== want.low_count) begin
					$error("low_count: expected %0d, got %0d",
						want.low_count, got.low_count);
					mismatches++;
				end
				if (got.edge_count !== want.edge_count) begin
					$error("edge_count: expected %0d, got %0d",
						want.edge_count, got.edge_count);
					mismatches++;
				end
			end
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && sample_if.ready) || (stats_if.valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("logic_channel_activity_stats_core_tb: FAIL");
				$finish;
			end
		end
	end

	initial begin
		int total;
		int r;
		logic [lcas_pkg::SAMPLE_W-1:0] last_s;
		logic [lcas_pkg::SAMPLE_W-1:0] s;
		logic [lcas_pkg::FUNC_W-1:0]   f;

		stats_clear();

		// directed corners
		add_item(lcas_pkg::FUNC_CLEAR, 8'h00, 3'd0);
		add_item(lcas_pkg::FUNC_READ,  8'hFF, 3'd0);
		add_item(lcas_pkg::FUNC_PUSH,  8'h00, 3'd7);   // first sample only stored
		add_item(FUNC_UNUSED,          8'hFF, 3'd7);
		add_item(lcas_pkg::FUNC_PUSH,  8'hFF, 3'd0);   // all channels toggle
		add_item(lcas_pkg::FUNC_PUSH,  8'hFF, 3'd1);   // steady high
		add_item(lcas_pkg::FUNC_PUSH,  8'h00, 3'd2);
		add_item(lcas_pkg::FUNC_PUSH,  8'h00, 3'd3);   // steady low
		add_item(lcas_pkg::FUNC_PUSH,  8'hA5, 3'd4);
		add_item(lcas_pkg::FUNC_PUSH,  8'h5A, 3'd5);
		for (int c = 0; c < NCH; c++)
			add_item(lcas_pkg::FUNC_READ, 8'(c * 37), 3'(c));
		add_item(FUNC_UNUSED,          8'h00, 3'd3);
		add_item(lcas_pkg::FUNC_CLEAR, 8'hFF, 3'd7);
		add_item(lcas_pkg::FUNC_PUSH,  8'h3C, 3'd2);   // first sample after clear
		add_item(lcas_pkg::FUNC_READ,  8'h00, 3'd2);
		add_item(lcas_pkg::FUNC_PUSH,  8'h3C, 3'd5);

		// random: mostly pushes of related samples so counters all move
		last_s = 8'h3C;
		for (int n = 0; n < 450; n++) begin
			r = $urandom_range(0, 99);
			if (r < 70)      f = lcas_pkg::FUNC_PUSH;
			else if (r < 88) f = lcas_pkg::FUNC_READ;
			else if (r < 94) f = FUNC_UNUSED;
			else             f = lcas_pkg::FUNC_CLEAR;
			case ($urandom_range(0, 2))
				0: s = last_s;
				1: s = last_s ^ (8'h01 << $urandom_range(0, 7));
				default: s = 8'($urandom());
			endcase
			if (f == lcas_pkg::FUNC_PUSH) last_s = s;
			add_item(f, s, 3'($urandom_range(0, 7)));
		end
		total = pending_items.size();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (accepted_items < total) @(posedge clk);
		while (expected_stats.size() > 0) @(posedge clk);
		repeat (10) @(posedge clk);

		if (mismatches == 0 && expected_stats.size() == 0) begin
			$display("logic_channel_activity_stats_core_tb: PASS");
		end else begin
			$display("logic_channel_activity_stats_core_tb: FAIL");
		end
		$finish;
	end

endmodule

// File: sim.f
src/lcas_pkg.sv
src/lcas_stream_if.sv
src/lcas_cell.sv
src/logic_channel_activity_stats_core.sv
src/lcas_checker.sv
tb/logic_channel_activity_stats_core_tb.sv
